// File: sv/nfi_pkg.sv
// Package for negative film inversion: widths, latencies, register indexes,
// fixed-point constants and output saturation. No dependencies.
package nfi_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DIV_W = 48;
	localparam int DIV_LAT = DIV_W;
	localparam int POW_LAT = 10;
	localparam int DLY_LAT = DIV_LAT + POW_LAT;
	localparam int OUT_LAT = DLY_LAT + 1;
	localparam int POW_W = 26;
	localparam int SUM_W = 34;

	localparam logic [POW_W-1:0] POW_CAP = POW_W'(1) << (POW_W - 1);
	localparam logic [31:0] LOG_BODGE_Q32 = 32'd1488665730;
	localparam logic [31:0] EXP_BODGE_Q32 = 32'd1459043340;

	localparam logic [2:0] REG_ENABLE     = 3'd0;
	localparam logic [2:0] REG_BASE_RED   = 3'd1;
	localparam logic [2:0] REG_BASE_GREEN = 3'd2;
	localparam logic [2:0] REG_BASE_BLUE  = 3'd3;
	localparam logic [2:0] REG_LIGHT      = 3'd4;
	localparam logic [2:0] REG_GREEN_EXP  = 3'd5;
	localparam logic [2:0] REG_BLUE_EXP   = 3'd6;

	typedef struct packed {
		logic        vld;
		logic        en;
		logic [2:0]  zero;
		logic [15:0] r;
		logic [15:0] g;
		logic [15:0] b;
	} nfi_side_t;

	function automatic logic [23:0] sat24(input logic signed [SUM_W-1:0] v);
		logic [23:0] res;
		if (v > 34'sd8388607) begin
			res = 24'h7FFFFF;
		end else if (v < -34'sd8388608) begin
			res = 24'h800000;
		end else begin
			res = v[23:0];
		end
		return res;
	endfunction

endpackage

// File: sv/nfi_div.sv
// Pipelined restoring divider, one quotient bit per stage: (num << 32) / den.
// Depends on nfi_pkg.
module nfi_div (
	input  logic                      clk,
	input  logic [15:0]               num,
	input  logic [15:0]               den,
	output logic [nfi_pkg::DIV_W-1:0] quo
);
	import nfi_pkg::*;

	logic [15:0]      rem_s [DIV_W];
	logic [DIV_W-1:0] quo_s [DIV_W];
	logic [15:0]      num_s [DIV_W];
	logic [15:0]      den_s [DIV_W];

	for (genvar i = 0; i < DIV_W; i++) begin : g_stg
		logic [15:0]      rem_in;
		logic [15:0]      num_in;
		logic [15:0]      den_in;
		logic [DIV_W-1:0] quo_in;
		logic [16:0]      trial;
		logic             ge;
		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign quo_in = '0;
			assign num_in = num;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign quo_in = quo_s[i-1];
			assign num_in = num_s[i-1];
			assign den_in = den_s[i-1];
		end
		assign trial = {rem_in, num_in[15]};
		assign ge = trial >= {1'b0, den_in};
		always_ff @(posedge clk) begin
			rem_s[i] <= ge ? 16'(trial - {1'b0, den_in}) : trial[15:0];
			quo_s[i] <= {quo_in[DIV_W-2:0], ge};
			num_s[i] <= {num_in[14:0], 1'b0};
			den_s[i] <= den_in;
		end
	end

	assign quo = quo_s[DIV_W-1];

endmodule

// File: sv/nfi_pow.sv
// Fast power (ratio ^ exponent) by approximate log2, multiply, approximate exp2.
// Ten register stages; result in Q.16 clamped to POW_CAP. Depends on nfi_pkg.
module nfi_pow #(
	parameter int FRAC_BITS = nfi_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [nfi_pkg::DIV_W-1:0] q,
	input  logic [15:0]               expo,
	output logic [nfi_pkg::POW_W-1:0] pow
);
	import nfi_pkg::*;

	localparam int F  = FRAC_BITS;
	localparam int LW = F + 8;
	localparam int PW = LW + 17;
	localparam int ZW = PW - 12;

	logic [POW_LAT-2:0] qz_s;

	// stage 1: coarse normalize
	logic [63:0] x0, x1, x2, x3;
	logic [2:0]  lzh;
	logic [63:0] x_s1;
	logic [2:0]  lzh_s1;

	assign x0 = 64'(q);
	assign lzh[2] = x0[63:32] == '0;
	assign x1 = lzh[2] ? (x0 << 32) : x0;
	assign lzh[1] = x1[63:48] == '0;
	assign x2 = lzh[1] ? (x1 << 16) : x1;
	assign lzh[0] = x2[63:56] == '0;
	assign x3 = lzh[0] ? (x2 << 8) : x2;

	// stage 2: fine normalize
	logic [63:0] y1, y2, y3;
	logic [2:0]  lzl;
	logic [5:0]  lz;
	logic [F-1:0] f_s2, f_s3, f_s4;
	logic [5:0]   p_s2, p_s3, p_s4;

	assign lzl[2] = x_s1[63:60] == '0;
	assign y1 = lzl[2] ? (x_s1 << 4) : x_s1;
	assign lzl[1] = y1[63:62] == '0;
	assign y2 = lzl[1] ? (y1 << 2) : y1;
	assign lzl[0] = !y2[63];
	assign y3 = lzl[0] ? (y2 << 1) : y2;
	assign lz = {lzh_s1, lzl};

	// stages 3 to 5: log2
	logic [2*F-1:0]  ff_s3;
	logic [F-1:0]    t;
	logic [F+31:0]   lb_s4;
	logic signed [7:0]    ip;
	logic signed [LW-1:0] lg;
	logic signed [LW-1:0] lg_s5;

	assign t = f_s3 - ff_s3[2*F-1:F];
	assign ip = $signed(8'({2'b0, p_s4}) - 8'd32);
	assign lg = $signed({ip, {F{1'b0}}}) + $signed(LW'(f_s4)) + $signed(LW'(lb_s4[F+31:32]));

	// stages 6 to 9: scale by exponent, exp2
	logic signed [PW-1:0] prod_s6;
	logic [ZW-1:0]        z;
	logic [ZW-1:0]        z_s7, z_s8;
	logic [2*F-1:0]       yy_s7;
	logic [F-1:0]         t2;
	logic [F+31:0]        eb_s8;
	logic [ZW-1:0]        w;
	logic signed [13:0]   sh;
	logic [F:0]           mant_s9;
	logic signed [13:0]   sh_s9;

	assign z = prod_s6[PW-1:12];
	assign t2 = z_s7[F-1:0] - yy_s7[2*F-1:F];
	assign w = z_s8 - ZW'(eb_s8[F+31:32]);
	assign sh = $signed(14'($signed(w[ZW-1:F]))) + $signed(14'(16 - F));

	// stage 10: shift into Q.16 and clamp
	logic [F+23:0]  lsh;
	logic [F:0]     rsh;
	logic [13:0]    nsh;
	logic [POW_W-1:0] pow_s10;

	assign lsh = (F+24)'(mant_s9) << sh_s9[4:0];
	assign nsh = 14'(-sh_s9);
	assign rsh = mant_s9 >> nsh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qz_s <= '0;
		end else begin
			qz_s <= {qz_s[POW_LAT-3:0], q == '0};
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= x3;
		lzh_s1 <= lzh;
		f_s2 <= y3[62 -: F];
		p_s2 <= 6'd63 - lz;
		ff_s3 <= (2*F)'(f_s2) * (2*F)'(f_s2);
		f_s3 <= f_s2;
		p_s3 <= p_s2;
		lb_s4 <= (F+32)'(t) * (F+32)'(LOG_BODGE_Q32);
		f_s4 <= f_s3;
		p_s4 <= p_s3;
		lg_s5 <= lg;
		prod_s6 <= $signed(PW'(lg_s5)) * $signed(PW'({1'b0, expo}));
		z_s7 <= z;
		yy_s7 <= (2*F)'(z[F-1:0]) * (2*F)'(z[F-1:0]);
		z_s8 <= z_s7;
		eb_s8 <= (F+32)'(t2) * (F+32)'(EXP_BODGE_Q32);
		mant_s9 <= {1'b1, w[F-1:0]};
		sh_s9 <= sh;
		if (qz_s[POW_LAT-2]) begin
			pow_s10 <= '0;
		end else if (sh_s9 >= 14'sd24) begin
			pow_s10 <= POW_CAP;
		end else if (sh_s9 >= 14'sd0) begin
			pow_s10 <= ((lsh >> (POW_W - 1)) != '0) ? POW_CAP : lsh[POW_W-1:0];
		end else begin
			pow_s10 <= POW_W'(rsh);
		end
	end

	assign pow = pow_s10;

endmodule

// File: sv/negative_film_inversion.sv
// Negative film inversion top level: config registers, dividers, power units.
// Depends on nfi_pkg, nfi_div and nfi_pow.
//
// Takes one pixel per clock whenever start is high; busy stays low. Each pixel
// produces one result, shown for one cycle with done; results leave in input
// order and the receiver cannot stall them. Each pixel passes through the
// 48-stage restoring divider (one quotient bit per stage) followed by the
// ten-stage log/multiply/exp power pipeline and one output stage.
// Configuration writes are always taken (cfg_ready high) and apply at once.
module negative_film_inversion #(
	parameter int FRAC_BITS = nfi_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] red_in,
	input  logic [15:0] green_in,
	input  logic [15:0] blue_in,
	output logic        done,
	output logic signed [23:0] red_out,
	output logic signed [23:0] green_out,
	output logic signed [23:0] blue_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import nfi_pkg::*;

	logic        enable_q;
	logic [15:0] base_red_q, base_green_q, base_blue_q, light_q, gexp_q, bexp_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			base_red_q <= '0;
			base_green_q <= '0;
			base_blue_q <= '0;
			light_q <= '0;
			gexp_q <= '0;
			bexp_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ENABLE:     enable_q <= cfg_data[0];
				REG_BASE_RED:   base_red_q <= cfg_data;
				REG_BASE_GREEN: base_green_q <= cfg_data;
				REG_BASE_BLUE:  base_blue_q <= cfg_data;
				REG_LIGHT:      light_q <= cfg_data;
				REG_GREEN_EXP:  gexp_q <= cfg_data;
				REG_BLUE_EXP:   bexp_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [DIV_W-1:0] q_r, q_g, q_b;
	logic [POW_W-1:0] pow_g, pow_b;

	nfi_div u_div_r (.clk(clk), .num(base_red_q),   .den(red_in),   .quo(q_r));
	nfi_div u_div_g (.clk(clk), .num(base_green_q), .den(green_in), .quo(q_g));
	nfi_div u_div_b (.clk(clk), .num(base_blue_q),  .den(blue_in),  .quo(q_b));

	nfi_pow #(.FRAC_BITS(FRAC_BITS)) u_pow_g (
		.clk(clk), .arst_n(arst_n), .q(q_g), .expo(gexp_q), .pow(pow_g)
	);
	nfi_pow #(.FRAC_BITS(FRAC_BITS)) u_pow_b (
		.clk(clk), .arst_n(arst_n), .q(q_b), .expo(bexp_q), .pow(pow_b)
	);

	nfi_side_t side_in;
	nfi_side_t side_s [DLY_LAT];
	logic [31:0] rq_s [POW_LAT];

	assign side_in = '{
		vld:  start && !busy,
		en:   enable_q,
		zero: {blue_in == '0, green_in == '0, red_in == '0},
		r:    red_in,
		g:    green_in,
		b:    blue_in
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DLY_LAT; i++) begin
				side_s[i] <= '0;
			end
		end else begin
			side_s[0] <= side_in;
			for (int i = 1; i < DLY_LAT; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		rq_s[0] <= q_r[47:16];
		for (int i = 1; i < POW_LAT; i++) begin
			rq_s[i] <= rq_s[i-1];
		end
	end

	nfi_side_t sd;
	logic signed [SUM_W-1:0] lt, red_v, green_v, blue_v;

	assign sd = side_s[DLY_LAT-1];
	assign lt = $signed(SUM_W'(light_q));
	assign red_v = $signed(SUM_W'(rq_s[POW_LAT-1])) - lt;
	assign green_v = $signed(SUM_W'(pow_g)) - lt;
	assign blue_v = $signed(SUM_W'(pow_b)) - lt;

	logic        done_q;
	logic [23:0] red_q, green_q, blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= sd.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (!sd.en) begin
			red_q <= 24'(sd.r);
			green_q <= 24'(sd.g);
			blue_q <= 24'(sd.b);
		end else begin
			red_q <= sd.zero[0] ? 24'h7FFFFF : sat24(red_v);
			green_q <= sd.zero[1] ? 24'h7FFFFF : sat24(green_v);
			blue_q <= sd.zero[2] ? 24'h7FFFFF : sat24(blue_v);
		end
	end

	assign done = done_q;
	assign red_out = $signed(red_q);
	assign green_out = $signed(green_q);
	assign blue_out = $signed(blue_q);

endmodule

// File: sv/nfi_chk.sv
// Port-level checker for negative film inversion, bound to the top level.
// Depends on nfi_pkg and negative_film_inversion.
module nfi_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic cfg_ready
);
	import nfi_pkg::*;

	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, OUT_LAT))
		else $error("result without a matching request");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !busy)
		else $error("busy raised in a fully pipelined block");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cfg_ready) |-> cfg_ready)
		else $error("config port dropped ready");

endmodule

bind negative_film_inversion nfi_chk u_nfi_chk (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.cfg_ready(cfg_ready)
);

// File: tb/sv/negative_film_inversion_chk.sv
// Checker for negative film inversion: tracks config writes and accepted pixels,
// predicts each result and compares it with the done strobe outputs.
// Depends on nfi_pkg for register indexes.
module negative_film_inversion_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [15:0] red_in,
	input  logic [15:0] green_in,
	input  logic [15:0] blue_in,
	input  logic        done,
	input  logic [23:0] red_out,
	input  logic [23:0] green_out,
	input  logic [23:0] blue_out,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          failures,
	output int          pending
);
	import nfi_pkg::*;

	localparam longint LOG_K = 64'd1488665730;
	localparam longint EXP_K = 64'd1459043340;

	typedef struct packed {
		logic [23:0] r;
		logic [23:0] g;
		logic [23:0] b;
	} pixel_t;

	logic        en;
	logic [15:0] base_r, base_g, base_b, light, exp_g, exp_b;
	pixel_t      expected_px[$];

	function automatic logic [23:0] clamp24(longint v);
		if (v > 64'sd8388607)
			return 24'h7FFFFF;
		if (v < -64'sd8388608)
			return 24'h800000;
		return v[23:0];
	endfunction

	function automatic longint film_power(logic [15:0] base, logic [15:0] pix,
			logic [15:0] gam);
		logic [63:0] q, m, f, t;
		int          p;
		longint      lg, z, w, k2, mant;
		q = ({48'd0, base} << 32) / {48'd0, pix};
		if (q == 0)
			return 0;
		p = 0;
		for (int i = 0; i < 64; i++)
			if (q[i])
				p = i;
		m = q - (64'd1 << p);
		f = (p >= 16) ? (m >> (p - 16)) : (m << (16 - p));
		t = f - ((f * f) >> 16);
		lg = longint'(p - 32) * 65536 + longint'(f) + longint'((t * LOG_K) >> 32);
		z = (lg * longint'({48'd0, gam})) >>> 12;
		f = 64'(z & 64'hFFFF);
		t = f - ((f * f) >> 16);
		w = z - longint'((t * EXP_K) >> 32);
		k2 = w >>> 16;
		mant = 65536 + (w & 64'hFFFF);
		if (k2 >= 24)
			return 64'sd1 << 48;
		if (k2 >= 0)
			return mant << k2;
		if (k2 < -62)
			return 0;
		return mant >> (-k2);
	endfunction

	function automatic logic [23:0] film_channel(logic [15:0] base, logic [15:0] pix,
			logic [15:0] gam);
		if (pix == 0)
			return 24'h7FFFFF;
		return clamp24(film_power(base, pix, gam) - longint'(light));
	endfunction

	function automatic pixel_t invert_pixel(logic [15:0] r, logic [15:0] g,
			logic [15:0] b);
		pixel_t o;
		if (!en)
			return '{24'(r), 24'(g), 24'(b)};
		if (r == 0)
			o.r = 24'h7FFFFF;
		else
			o.r = clamp24(longint'(({48'd0, base_r} << 16) / {48'd0, r}) - longint'(light));
		o.g = film_channel(base_g, g, exp_g);
		o.b = film_channel(base_b, b, exp_b);
		return o;
	endfunction

	assign pending = expected_px.size();

	always @(posedge clk or negedge arst_n) begin
		pixel_t e;
		int     errs;
		if (!arst_n) begin
			en <= 1'b0;
			base_r <= '0;
			base_g <= '0;
			base_b <= '0;
			light <= '0;
			exp_g <= '0;
			exp_b <= '0;
			failures <= 0;
			expected_px.delete();
		end else begin
			errs = 0;
			if (done) begin
				if (expected_px.size() == 0) begin
					$error("result with no request outstanding");
					errs = errs + 1;
				end else begin
					e = expected_px.pop_front();
					if (red_out !== e.r) begin
						$error("red_out expected %0h got %0h", e.r, red_out);
						errs = errs + 1;
					end
					if (green_out !== e.g) begin
						$error("green_out expected %0h got %0h", e.g, green_out);
						errs = errs + 1;
					end
					if (blue_out !== e.b) begin
						$error("blue_out expected %0h got %0h", e.b, blue_out);
						errs = errs + 1;
					end
				end
			end
			failures <= failures + errs;
			if (start && !busy)
				expected_px.push_back(invert_pixel(red_in, green_in, blue_in));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ENABLE:     en <= cfg_data[0];
					REG_BASE_RED:   base_r <= cfg_data;
					REG_BASE_GREEN: base_g <= cfg_data;
					REG_BASE_BLUE:  base_b <= cfg_data;
					REG_LIGHT:      light <= cfg_data;
					REG_GREEN_EXP:  exp_g <= cfg_data;
					REG_BLUE_EXP:   exp_b <= cfg_data;
					default: ;
				endcase
			end
		end
	end
endmodule

// File: tb/sv/negative_film_inversion_tb.sv
// Testbench top for negative film inversion: clock, reset, config phases and
// pixel stimulus. Depends on nfi_pkg, the block and negative_film_inversion_chk.
module negative_film_inversion_tb;
	import nfi_pkg::*;

	localparam int LIMIT = 300000;
	localparam logic [2:0] REG_UNUSED = 3'd7;

	logic        clk, arst_n, start, busy, done, cfg_valid, cfg_ready;
	logic [15:0] red_in, green_in, blue_in, cfg_data;
	logic [23:0] red_out, green_out, blue_out;
	logic [2:0]  cfg_index;
	int          failures, pending, cycles;
	bit          quiet;

	negative_film_inversion DUT (.*);

	negative_film_inversion_chk checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("negative_film_inversion: mismatch");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic send(logic [15:0] r, logic [15:0] g, logic [15:0] b);
		start <= 1'b1;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		do @(posedge clk); while (busy);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	function automatic logic [15:0] rand_pix;
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 3));
			1: return 16'($urandom_range(0, 255));
			2: return 16'hFFFF - 16'($urandom_range(0, 3));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic set_all(logic en, logic [15:0] br, logic [15:0] bg, logic [15:0] bb,
			logic [15:0] lo, logic [15:0] eg, logic [15:0] eb);
		drain();
		write_reg(REG_ENABLE, {15'd0, en});
		write_reg(REG_BASE_RED, br);
		write_reg(REG_BASE_GREEN, bg);
		write_reg(REG_BASE_BLUE, bb);
		write_reg(REG_LIGHT, lo);
		write_reg(REG_GREEN_EXP, eg);
		write_reg(REG_BLUE_EXP, eb);
	endtask

	task automatic directed_set;
		send(16'h0000, 16'h0000, 16'h0000);
		send(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send(16'h0001, 16'h0001, 16'h0001);
		send(16'h8000, 16'h4000, 16'h2000);
		send(16'h0000, 16'h1234, 16'hFFFF);
		send(16'hABCD, 16'h0000, 16'h5555);
		send(16'h00FF, 16'hAAAA, 16'h0000);
	endtask

	initial begin
		quiet = 1'b0;
		start = 1'b0;
		red_in = '0;
		green_in = '0;
		blue_in = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_set();
		set_all(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h1000, 16'h1000);
		directed_set();
		set_all(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h1000, 16'h0000, 16'hFFFF);
		directed_set();
		set_all(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
		directed_set();
		drain();
		write_reg(REG_UNUSED, 16'hFFFF);
		write_reg(REG_ENABLE, 16'hFFFE);

		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 8)
				quiet = 1'b1;
			if (ph == 1)
				set_all(1'b0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
			else
				set_all(1'b1, rand_pix(), rand_pix(), rand_pix(),
					16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 255)),
					16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 16384)),
					16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 16384)));
			repeat (112) send(rand_pix(), rand_pix(), rand_pix());
		end

		drain();
		repeat (OUT_LAT + 10) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("negative_film_inversion: match");
		else
			$display("negative_film_inversion: mismatch");
		$finish;
	end
endmodule

// File: sim.f
sv/nfi_pkg.sv
sv/nfi_div.sv
sv/nfi_pow.sv
sv/negative_film_inversion.sv
sv/nfi_chk.sv
tb/sv/negative_film_inversion_chk.sv
tb/sv/negative_film_inversion_tb.sv
